// ===== src/sshs_pkg.sv =====
package sshs_pkg;

    localparam int HALF_TURN    = 23040;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int FACE_TOL     = 128;
    localparam int MOVE_TOL     = 3840;

    localparam int POS_W   = 32;
    localparam int HOFF_W  = 20;
    localparam int CUR_W   = 18;
    localparam int SPEED_W = 15;
    localparam int STOP_W  = 31;
    localparam int YAW_W   = 18;
    localparam int PITCH_W = 17;

    localparam int MAG_W    = 34;
    localparam int HALF_MAG = MAG_W / 2;
    localparam int PP_W     = 2 * HALF_MAG;
    localparam int SQ_W     = 2 * MAG_W;

    localparam int SQRT_PAD   = 32;
    localparam int RAD_W      = SQ_W + SQRT_PAD;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int REM_W      = SQRT_STEPS + 2;

    localparam int ELEV_SH      = 16;
    localparam int ATAN_IN_W    = SQRT_STEPS;
    localparam int NORM_W       = 64;
    localparam int NORM_STEPS   = $clog2(NORM_W);
    localparam int MANT_W       = 30;
    localparam int CX_W         = 33;
    localparam int CZ_W         = 24;
    localparam int CORDIC_STEPS = 22;
    localparam int ANG_IDX_W    = $clog2(CORDIC_STEPS);
    localparam int RND_SH       = 8;
    localparam int ANG_W        = 14;
    localparam int Z_MAX        = 2949120;

    localparam int GOAL_W     = 17;
    localparam int ANGLE_W    = 21;
    localparam int WRAP_STEPS = 4;

    localparam int FRONT_LAT = 5;
    localparam int ATAN_LAT  = NORM_STEPS + CORDIC_STEPS + 2;
    localparam int SLEW_LAT  = WRAP_STEPS + 1;
    localparam int SIDE_LEN  = SQRT_STEPS + ATAN_LAT;
    localparam int TOT_LAT   = FRONT_LAT + SIDE_LEN + SLEW_LAT + 2;

    typedef enum logic [1:0] {
        Q_GEN,
        Q_ZERO,
        Q_RIGHT
    } t_quad;

    typedef struct packed {
        logic [MAG_W-1:0]         ax;
        logic [MAG_W-1:0]         ay;
        logic [MAG_W-1:0]         az;
        logic                     nx;
        logic                     ny;
        logic                     nz;
        logic                     arrived;
        logic signed [CUR_W-1:0]  cyaw;
        logic signed [CUR_W-1:0]  cpitch;
        logic [SPEED_W-1:0]       speed;
    } t_side;

    function automatic logic signed [CZ_W-1:0] cordic_ang(input logic [ANG_IDX_W-1:0] idx);
        case (idx)
            5'd0:    cordic_ang = CZ_W'(1474560);
            5'd1:    cordic_ang = CZ_W'(870484);
            5'd2:    cordic_ang = CZ_W'(459940);
            5'd3:    cordic_ang = CZ_W'(233473);
            5'd4:    cordic_ang = CZ_W'(117189);
            5'd5:    cordic_ang = CZ_W'(58652);
            5'd6:    cordic_ang = CZ_W'(29333);
            5'd7:    cordic_ang = CZ_W'(14667);
            5'd8:    cordic_ang = CZ_W'(7334);
            5'd9:    cordic_ang = CZ_W'(3667);
            5'd10:   cordic_ang = CZ_W'(1833);
            5'd11:   cordic_ang = CZ_W'(917);
            5'd12:   cordic_ang = CZ_W'(458);
            5'd13:   cordic_ang = CZ_W'(229);
            5'd14:   cordic_ang = CZ_W'(115);
            5'd15:   cordic_ang = CZ_W'(57);
            5'd16:   cordic_ang = CZ_W'(29);
            5'd17:   cordic_ang = CZ_W'(14);
            5'd18:   cordic_ang = CZ_W'(7);
            5'd19:   cordic_ang = CZ_W'(4);
            5'd20:   cordic_ang = CZ_W'(2);
            5'd21:   cordic_ang = CZ_W'(1);
            default: cordic_ang = '0;
        endcase
    endfunction

endpackage

// ===== src/seek_heading_slew_step_top.sv =====
// Throughput: one item per cycle; busy stays low.
// Depth comes from the 50-stage square root and the two 30-stage arctangent units.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (i_rst_n low, synchronous) clears all valid bits; in-flight items are dropped.
module seek_heading_slew_step_top import sshs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [HOFF_W-1:0]        i_height_offset,
    input  logic signed [CUR_W-1:0]  i_cur_yaw,
    input  logic signed [CUR_W-1:0]  i_cur_pitch,
    input  logic signed [POS_W-1:0]  i_target_x,
    input  logic signed [POS_W-1:0]  i_target_y,
    input  logic signed [POS_W-1:0]  i_target_z,
    input  logic                     i_reverse,
    input  logic [SPEED_W-1:0]       i_turn_speed,
    input  logic [STOP_W-1:0]        i_stop_distance,
    output logic                     o_valid,
    output logic signed [YAW_W-1:0]  o_new_yaw,
    output logic signed [PITCH_W-1:0] o_new_pitch,
    output logic                     o_move_forward,
    output logic                     o_done_res
);

    localparam int LANES = 4;
    localparam int LN_X  = 0;
    localparam int LN_Y  = 1;
    localparam int LN_Z  = 2;
    localparam int LN_S  = 3;
    localparam int DZ_W  = POS_W + 3;
    localparam logic signed [GOAL_W-1:0] HALF_G = GOAL_W'(HALF_TURN);

    logic accept;

    logic                    r_vld [TOT_LAT];

    logic signed [POS_W:0]   r1_dx;
    logic signed [POS_W:0]   r1_dy;
    logic signed [DZ_W-1:0]  r1_dz;
    logic                    r1_rev;
    logic signed [CUR_W-1:0] r1_cyaw;
    logic signed [CUR_W-1:0] r1_cpitch;
    logic [SPEED_W-1:0]      r1_speed;
    logic [STOP_W-1:0]       r1_stop;

    t_side                   r2_side;
    logic [STOP_W-1:0]       r2_stop;
    t_side                   r3_side;
    t_side                   r4_side;
    t_side                   r5_side;
    logic [PP_W-1:0]         r3_hh [LANES];
    logic [PP_W-1:0]         r3_hl [LANES];
    logic [PP_W-1:0]         r3_ll [LANES];
    logic [SQ_W-1:0]         r4_sq [LANES];
    logic [SQ_W-1:0]         r5_hsq;
    logic [SQ_W-1:0]         r5_azsq;
    logic [SQ_W-1:0]         r5_stsq;

    t_side                   r_side [SIDE_LEN];

    logic signed [GOAL_W-1:0] r_p1_yg;
    logic signed [GOAL_W-1:0] r_p1_pg;
    logic signed [CUR_W-1:0]  r_p1_cyaw;
    logic signed [CUR_W-1:0]  r_p1_cpitch;
    logic [SPEED_W-1:0]       r_p1_spd;
    logic                     r_arr [SLEW_LAT+1];

    logic signed [YAW_W-1:0]   r_out_yaw;
    logic signed [PITCH_W-1:0] r_out_pitch;
    logic                      r_out_move;
    logic                      r_out_done;

    logic signed [POS_W:0]    n_ndx;
    logic signed [POS_W:0]    n_ndy;
    logic signed [DZ_W-1:0]   n_ndz;
    logic signed [DZ_W-1:0]   n_adz;
    t_side                    n_side2;
    logic [MAG_W-1:0]         n_src [LANES];
    logic [SQ_W:0]            n_dsq;
    t_side                    n_side0;
    t_side                    n_mid;
    t_side                    n_tail;
    logic signed [GOAL_W-1:0] n_qy;
    logic signed [GOAL_W-1:0] n_qp;
    logic signed [GOAL_W-1:0] n_bear0;
    logic signed [GOAL_W-1:0] n_bear;
    logic signed [GOAL_W-1:0] n_yg;
    logic signed [GOAL_W-1:0] n_pg;
    logic signed [ANGLE_W-1:0] n_ygx;
    logic signed [ANGLE_W-1:0] n_diff;
    logic signed [ANGLE_W-1:0] n_adiff;

    logic [SQRT_STEPS-1:0]     hq;
    logic [ANG_W-1:0]          yaw_q;
    logic [ANG_W-1:0]          pitch_q;
    logic signed [ANGLE_W-1:0] slew_yaw;
    logic signed [ANGLE_W-1:0] slew_pitch;
    logic signed [GOAL_W-1:0]  slew_yg;
    logic signed [GOAL_W-1:0]  slew_pg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int k = 1; k < TOT_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx     <= $signed({i_target_x[POS_W-1], i_target_x})
                   - $signed({i_pos_x[POS_W-1], i_pos_x});
        r1_dy     <= $signed({i_target_y[POS_W-1], i_target_y})
                   - $signed({i_pos_y[POS_W-1], i_pos_y});
        r1_dz     <= $signed({{3{i_target_z[POS_W-1]}}, i_target_z})
                   - $signed({{3{i_pos_z[POS_W-1]}}, i_pos_z})
                   + $signed({{(DZ_W-HOFF_W){1'b0}}, i_height_offset});
        r1_rev    <= i_reverse;
        r1_cyaw   <= i_cur_yaw;
        r1_cpitch <= i_cur_pitch;
        r1_speed  <= i_turn_speed;
        r1_stop   <= i_stop_distance;
    end

    always_comb begin
        n_ndx = -r1_dx;
        n_ndy = -r1_dy;
        n_ndz = -r1_dz;
        n_adz = r1_dz[DZ_W-1] ? n_ndz : r1_dz;
        n_side2.ax      = {1'b0, (r1_dx[POS_W] ? n_ndx : r1_dx)};
        n_side2.ay      = {1'b0, (r1_dy[POS_W] ? n_ndy : r1_dy)};
        n_side2.az      = n_adz[MAG_W-1:0];
        n_side2.nx      = r1_rev ? (!r1_dx[POS_W] && r1_dx != '0) : r1_dx[POS_W];
        n_side2.ny      = r1_rev ? (!r1_dy[POS_W] && r1_dy != '0) : r1_dy[POS_W];
        n_side2.nz      = r1_rev ? (!r1_dz[DZ_W-1] && r1_dz != '0) : r1_dz[DZ_W-1];
        n_side2.arrived = 1'b0;
        n_side2.cyaw    = r1_cyaw;
        n_side2.cpitch  = r1_cpitch;
        n_side2.speed   = r1_speed;
    end

    always_ff @(posedge i_clk) begin
        r2_side <= n_side2;
        r2_stop <= r1_stop;
    end

    always_comb begin
        n_src[LN_X] = r2_side.ax;
        n_src[LN_Y] = r2_side.ay;
        n_src[LN_Z] = r2_side.az;
        n_src[LN_S] = {{(MAG_W-STOP_W){1'b0}}, r2_stop};
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [HALF_MAG-1:0] hi;
        logic [HALF_MAG-1:0] lo;
        assign hi = n_src[k][MAG_W-1 -: HALF_MAG];
        assign lo = n_src[k][HALF_MAG-1:0];
        always_ff @(posedge i_clk) begin
            r3_hh[k] <= hi * hi;
            r3_hl[k] <= hi * lo;
            r3_ll[k] <= lo * lo;
            r4_sq[k] <= {r3_hh[k], {PP_W{1'b0}}}
                      + SQ_W'({r3_hl[k], {(HALF_MAG+1){1'b0}}})
                      + SQ_W'(r3_ll[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r3_side <= r2_side;
        r4_side <= r3_side;
        r5_side <= r4_side;
        r5_hsq  <= r4_sq[LN_X] + r4_sq[LN_Y];
        r5_azsq <= r4_sq[LN_Z];
        r5_stsq <= r4_sq[LN_S];
    end

    always_comb begin
        n_dsq           = {1'b0, r5_hsq} + {1'b0, r5_azsq};
        n_side0         = r5_side;
        n_side0.arrived = n_dsq <= {1'b0, r5_stsq};
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side0;
        for (int k = 1; k < SIDE_LEN; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    sshs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r5_hsq),
        .o_root (hq)
    );

    assign n_mid  = r_side[SQRT_STEPS-1];
    assign n_tail = r_side[SIDE_LEN-1];

    sshs_atan u_atan_yaw (
        .i_clk (i_clk),
        .i_a   ({{(ATAN_IN_W-MAG_W){1'b0}}, n_mid.ay}),
        .i_b   ({{(ATAN_IN_W-MAG_W){1'b0}}, n_mid.ax}),
        .o_ang (yaw_q)
    );

    sshs_atan u_atan_pitch (
        .i_clk (i_clk),
        .i_a   (hq),
        .i_b   (ATAN_IN_W'({n_mid.az, {ELEV_SH{1'b0}}})),
        .o_ang (pitch_q)
    );

    always_comb begin
        n_qy    = {{(GOAL_W-ANG_W){1'b0}}, yaw_q};
        n_qp    = {{(GOAL_W-ANG_W){1'b0}}, pitch_q};
        n_bear0 = n_tail.ny ? HALF_G - n_qy : n_qy;
        n_bear  = n_tail.nx ? -n_bear0 : n_bear0;
        n_yg    = HALF_G - n_bear;
        n_pg    = n_tail.nz ? -n_qp : n_qp;
    end

    always_ff @(posedge i_clk) begin
        r_p1_yg     <= n_yg;
        r_p1_pg     <= n_pg;
        r_p1_cyaw   <= n_tail.cyaw;
        r_p1_cpitch <= n_tail.cpitch;
        r_p1_spd    <= n_tail.speed;
        r_arr[0]    <= n_tail.arrived;
        for (int k = 1; k <= SLEW_LAT; k++) begin
            r_arr[k] <= r_arr[k-1];
        end
    end

    sshs_slew u_slew_yaw (
        .i_clk   (i_clk),
        .i_cur   (r_p1_cyaw),
        .i_goal  (r_p1_yg),
        .i_speed (r_p1_spd),
        .o_new   (slew_yaw),
        .o_goal  (slew_yg)
    );

    sshs_slew u_slew_pitch (
        .i_clk   (i_clk),
        .i_cur   (r_p1_cpitch),
        .i_goal  (r_p1_pg),
        .i_speed (r_p1_spd),
        .o_new   (slew_pitch),
        .o_goal  (slew_pg)
    );

    always_comb begin
        n_ygx   = {{(ANGLE_W-GOAL_W){slew_yg[GOAL_W-1]}}, slew_yg};
        n_diff  = slew_yaw - n_ygx;
        n_adiff = n_diff[ANGLE_W-1] ? -n_diff : n_diff;
    end

    always_ff @(posedge i_clk) begin
        r_out_yaw   <= slew_yaw[YAW_W-1:0];
        r_out_pitch <= slew_pitch[PITCH_W-1:0];
        r_out_move  <= !r_arr[SLEW_LAT] && (n_adiff <= ANGLE_W'(MOVE_TOL)) && (slew_pg == slew_pg);
        r_out_done  <= r_arr[SLEW_LAT] && (n_adiff < ANGLE_W'(FACE_TOL));
    end

    assign o_valid        = r_vld[TOT_LAT-1];
    assign o_new_yaw      = r_out_yaw;
    assign o_new_pitch    = r_out_pitch;
    assign o_move_forward = r_out_move;
    assign o_done_res     = r_out_done;

endmodule

// ===== src/sshs_sqrt.sv =====
module sshs_sqrt import sshs_pkg::*; (
    input  logic                  i_clk,
    input  logic [SQ_W-1:0]       i_rad,
    output logic [SQRT_STEPS-1:0] o_root
);

    logic [SQ_W-1:0]       r_rad  [SQRT_STEPS-1];
    logic [REM_W-1:0]      r_rem  [SQRT_STEPS-1];
    logic [SQRT_STEPS-1:0] r_root [SQRT_STEPS];

    for (genvar p = 0; p < SQRT_STEPS; p++) begin : g_stage
        logic [SQ_W-1:0]       rad_in;
        logic [REM_W-1:0]      rem_in;
        logic [SQRT_STEPS-1:0] root_in;
        logic [RAD_W-1:0]      hs;
        logic [REM_W+1:0]      rem_sh;
        logic [REM_W+1:0]      trial;
        logic                  ge;

        if (p == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[p-1];
            assign rem_in  = r_rem[p-1];
            assign root_in = r_root[p-1];
        end

        assign hs     = {rad_in, {SQRT_PAD{1'b0}}};
        assign rem_sh = {rem_in, hs[2*(SQRT_STEPS-1-p) +: 2]};
        assign trial  = {{(REM_W-SQRT_STEPS){1'b0}}, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            r_root[p] <= {root_in[SQRT_STEPS-2:0], ge};
        end

        if (p < SQRT_STEPS - 1) begin : g_carry
            logic [REM_W+1:0] rem_sub;
            assign rem_sub = ge ? rem_sh - trial : rem_sh;
            always_ff @(posedge i_clk) begin
                r_rem[p] <= rem_sub[REM_W-1:0];
                r_rad[p] <= rad_in;
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule

// ===== src/sshs_atan.sv =====
module sshs_atan import sshs_pkg::*; (
    input  logic                 i_clk,
    input  logic [ATAN_IN_W-1:0] i_a,
    input  logic [ATAN_IN_W-1:0] i_b,
    output logic [ANG_W-1:0]     o_ang
);

    localparam logic signed [CZ_W-1:0] ZMAX_C = CZ_W'(Z_MAX);
    localparam logic signed [CZ_W-1:0] RND_C  = CZ_W'(1 << (RND_SH - 1));

    logic [NORM_W-1:0]       r_na [NORM_STEPS+1];
    logic [NORM_W-1:0]       r_nb [NORM_STEPS+1];
    t_quad                   r_ns [NORM_STEPS+1];
    logic signed [CX_W-1:0]  r_cx [CORDIC_STEPS];
    logic signed [CX_W-1:0]  r_cy [CORDIC_STEPS];
    logic signed [CZ_W-1:0]  r_cz [CORDIC_STEPS];
    t_quad                   r_cs [CORDIC_STEPS];
    logic [ANG_W-1:0]        r_ang;

    logic signed [CZ_W-1:0]  n_zc;
    logic signed [CZ_W-1:0]  n_zr;
    logic [ANG_W-1:0]        n_ang;

    always_ff @(posedge i_clk) begin
        r_na[0] <= {{(NORM_W-ATAN_IN_W){1'b0}}, i_a};
        r_nb[0] <= {{(NORM_W-ATAN_IN_W){1'b0}}, i_b};
        if (i_b == '0) begin
            r_ns[0] <= Q_ZERO;
        end else if (i_a == '0) begin
            r_ns[0] <= Q_RIGHT;
        end else begin
            r_ns[0] <= Q_GEN;
        end
    end

    for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
        localparam int SH = NORM_W >> j;
        logic [NORM_W-1:0] orab;
        logic              hit;
        assign orab = r_na[j-1] | r_nb[j-1];
        assign hit  = orab[NORM_W-1 -: SH] == '0;
        always_ff @(posedge i_clk) begin
            r_na[j] <= hit ? r_na[j-1] << SH : r_na[j-1];
            r_nb[j] <= hit ? r_nb[j-1] << SH : r_nb[j-1];
            r_ns[j] <= r_ns[j-1];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CX_W-1:0] x_in;
        logic signed [CX_W-1:0] y_in;
        logic signed [CZ_W-1:0] z_in;
        t_quad                  s_in;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        logic signed [CZ_W-1:0] ang;

        if (i == 0) begin : g_first
            assign x_in = $signed({{(CX_W-MANT_W){1'b0}},
                                   r_na[NORM_STEPS][NORM_W-1 -: MANT_W]});
            assign y_in = $signed({{(CX_W-MANT_W){1'b0}},
                                   r_nb[NORM_STEPS][NORM_W-1 -: MANT_W]});
            assign z_in = '0;
            assign s_in = r_ns[NORM_STEPS];
        end else begin : g_next
            assign x_in = r_cx[i-1];
            assign y_in = r_cy[i-1];
            assign z_in = r_cz[i-1];
            assign s_in = r_cs[i-1];
        end

        assign xs  = x_in >>> i;
        assign ys  = y_in >>> i;
        assign ang = cordic_ang(ANG_IDX_W'(i));

        always_ff @(posedge i_clk) begin
            if (!y_in[CX_W-1]) begin
                r_cx[i] <= x_in + ys;
                r_cy[i] <= y_in - xs;
                r_cz[i] <= z_in + ang;
            end else begin
                r_cx[i] <= x_in - ys;
                r_cy[i] <= y_in + xs;
                r_cz[i] <= z_in - ang;
            end
            r_cs[i] <= s_in;
        end
    end

    always_comb begin
        if (r_cz[CORDIC_STEPS-1] < 0) begin
            n_zc = '0;
        end else if (r_cz[CORDIC_STEPS-1] > ZMAX_C) begin
            n_zc = ZMAX_C;
        end else begin
            n_zc = r_cz[CORDIC_STEPS-1];
        end
        n_zr = n_zc + RND_C;
        case (r_cs[CORDIC_STEPS-1])
            Q_ZERO:  n_ang = '0;
            Q_RIGHT: n_ang = ANG_W'(QUARTER_TURN);
            default: n_ang = n_zr[ANG_W+RND_SH-1:RND_SH];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ang <= n_ang;
    end

    assign o_ang = r_ang;

endmodule

// ===== src/sshs_slew.sv =====
module sshs_slew import sshs_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [CUR_W-1:0]   i_cur,
    input  logic signed [GOAL_W-1:0]  i_goal,
    input  logic [SPEED_W-1:0]        i_speed,
    output logic signed [ANGLE_W-1:0] o_new,
    output logic signed [GOAL_W-1:0]  o_goal
);

    localparam logic signed [ANGLE_W-1:0] HALF_A = ANGLE_W'(HALF_TURN);
    localparam logic signed [ANGLE_W-1:0] FULL_A = ANGLE_W'(FULL_TURN);

    logic signed [ANGLE_W-1:0] r_cur  [WRAP_STEPS];
    logic signed [GOAL_W-1:0]  r_goal [WRAP_STEPS];
    logic [SPEED_W-1:0]        r_spd  [WRAP_STEPS];
    logic signed [ANGLE_W-1:0] r_new;
    logic signed [GOAL_W-1:0]  r_goal_o;

    logic signed [ANGLE_W-1:0] n_goal;
    logic signed [ANGLE_W-1:0] n_spd;
    logic signed [ANGLE_W-1:0] n_cur;
    logic signed [ANGLE_W-1:0] n_step;
    logic signed [ANGLE_W-1:0] n_new;
    logic                      n_up;
    logic                      n_dn;

    for (genvar w = 0; w < WRAP_STEPS; w++) begin : g_wrap
        logic signed [ANGLE_W-1:0] cur_in;
        logic signed [GOAL_W-1:0]  goal_in;
        logic [SPEED_W-1:0]        spd_in;
        logic signed [ANGLE_W-1:0] goal_x;

        if (w == 0) begin : g_first
            assign cur_in  = {{(ANGLE_W-CUR_W){i_cur[CUR_W-1]}}, i_cur};
            assign goal_in = i_goal;
            assign spd_in  = i_speed;
        end else begin : g_next
            assign cur_in  = r_cur[w-1];
            assign goal_in = r_goal[w-1];
            assign spd_in  = r_spd[w-1];
        end

        assign goal_x = {{(ANGLE_W-GOAL_W){goal_in[GOAL_W-1]}}, goal_in};

        always_ff @(posedge i_clk) begin
            if (cur_in < goal_x - HALF_A) begin
                r_cur[w] <= cur_in + FULL_A;
            end else if (cur_in > goal_x + HALF_A) begin
                r_cur[w] <= cur_in - FULL_A;
            end else begin
                r_cur[w] <= cur_in;
            end
            r_goal[w] <= goal_in;
            r_spd[w]  <= spd_in;
        end
    end

    always_comb begin
        n_goal = {{(ANGLE_W-GOAL_W){r_goal[WRAP_STEPS-1][GOAL_W-1]}}, r_goal[WRAP_STEPS-1]};
        n_spd  = {{(ANGLE_W-SPEED_W){1'b0}}, r_spd[WRAP_STEPS-1]};
        n_cur  = r_cur[WRAP_STEPS-1];
        n_up   = n_goal > n_cur;
        n_dn   = n_goal < n_cur;
        if (n_up) begin
            n_step = n_cur + n_spd;
        end else if (n_dn) begin
            n_step = n_cur - n_spd;
        end else begin
            n_step = n_cur;
        end
        if ((n_up && n_step > n_goal) || (n_dn && n_step < n_goal)) begin
            n_new = n_goal;
        end else begin
            n_new = n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_goal_o <= r_goal[WRAP_STEPS-1];
    end

    assign o_new  = r_new;
    assign o_goal = r_goal_o;

endmodule

// ===== src/sshs_chk.sv =====
module sshs_chk import sshs_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic signed [YAW_W-1:0]   o_new_yaw,
    input logic signed [PITCH_W-1:0] o_new_pitch,
    input logic                      o_move_forward,
    input logic                      o_done_res
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOT_LAT o_valid)
        else $error("item accepted without result");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, TOT_LAT))
        else $error("result without accepted item");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_move_forward && o_done_res))
        else $error("move and done both set");

    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_pitch >= -(HALF_TURN + QUARTER_TURN)
                     && o_new_pitch <= (HALF_TURN + QUARTER_TURN)))
        else $error("pitch out of range");

endmodule

bind seek_heading_slew_step_top sshs_chk u_chk (.*);
